// File: rtl/cal_pkg.sv
// Shared constants, codes and types for the cursor array list.
`default_nettype none
package cal_pkg;

   localparam int DEPTH  = 16;
   localparam int ELEM_W = 32;
   localparam int CUR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int OP_W   = 3;
   localparam int ST_W   = 2;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      REQ_READ   = 3'd0,
      REQ_INSERT = 3'd1,
      REQ_REMOVE = 3'd2,
      REQ_JUMP   = 3'd3,
      REQ_START  = 3'd4,
      REQ_END    = 3'd5,
      REQ_PREV   = 3'd6,
      REQ_NEXT   = 3'd7
   } cal_op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NO_ELEMENT = 2'd2,
      ST_RANGE      = 2'd3
   } cal_status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              insert;
      logic              remove;
      logic [CUR_W-1:0]  cursor;
      logic [ELEM_W-1:0] new_value;
   } cal_ctl_type;

endpackage
`default_nettype wire

// File: rtl/cursor_array_list_unit.sv
// Top level of the cursor array list: request decode, cursor and count, chain of cells.
// Latency: a result word appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle unless a result stalls; cells from the cursor up shift.
// A result waiting in the output register does not block the next request if rsp_ready is high.
// Reset (synchronous, active high): count 0, cursor 0, capacity 16, no result pending.
// Cell contents are not cleared; a cell is only read after it has been written.
`default_nettype none
module cursor_array_list_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [cal_pkg::OP_W-1:0]   req_type,
   input  wire logic [cal_pkg::ELEM_W-1:0] req_new_value,
   input  wire logic [cal_pkg::CUR_W-1:0]  req_target_position,
   // result channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [cal_pkg::ELEM_W-1:0] rsp_read_value,
   output logic      [cal_pkg::ST_W-1:0]   rsp_status,
   output logic      [cal_pkg::CUR_W-1:0]  rsp_cursor_now,
   output logic      [cal_pkg::CNT_W-1:0]  rsp_count_now,
   // capacity register write
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [cal_pkg::CNT_W-1:0]  csr_data
);
   import cal_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // control state
   logic [CNT_W-1:0] count_ff,    count_in;
   logic [CUR_W-1:0] cursor_ff,   cursor_in;
   logic [CNT_W-1:0] capacity_ff;
   logic             rsp_valid_ff;

   // result payload
   logic [ELEM_W-1:0] rsp_read_ff, read_in;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [CUR_W-1:0]  rsp_cursor_ff;
   logic [CNT_W-1:0]  rsp_count_ff;

   cal_op_type        op;
   cal_status_type    status_in;
   logic              accept;
   logic              do_insert;
   logic              do_remove;
   logic [CNT_W-1:0]  eff_cap;
   logic [CNT_W-1:0]  cursor_ext;
   logic [ELEM_W-1:0] cur_value;
   cal_ctl_type       ctl;
   logic [ELEM_W-1:0] cell_value [DEPTH];

   // output register frees itself when the consumer takes the word
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign op         = cal_op_type'(req_type);
   assign eff_cap    = (capacity_ff > DEPTH_CNT) ? DEPTH_CNT : capacity_ff;
   assign cursor_ext = CNT_W'(cursor_ff);
   assign cur_value  = cell_value[cursor_ff];

   // request decode: status, new cursor and count, chain command
   always_comb begin
      status_in = ST_OK;
      read_in   = '0;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      do_insert = 1'b0;
      do_remove = 1'b0;
      unique case (op)
         REQ_READ: begin
            if (cursor_ext >= count_ff) begin
               status_in = ST_NO_ELEMENT;
            end else begin
               read_in = cur_value;
            end
         end
         REQ_INSERT: begin
            if (count_ff >= eff_cap || count_ff >= DEPTH_CNT || cursor_ext > count_ff) begin
               status_in = ST_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_REMOVE: begin
            if (cursor_ext >= count_ff) begin
               status_in = ST_NO_ELEMENT;
            end else begin
               read_in   = cur_value;
               do_remove = 1'b1;
               count_in  = count_ff - CNT_W'(1);
               // cursor fell off the end: step back one
               if (cursor_ext == count_in && cursor_ff != '0) begin
                  cursor_in = cursor_ff - CUR_W'(1);
               end
            end
         end
         REQ_JUMP: begin
            if (CNT_W'(req_target_position) >= count_ff) begin
               status_in = ST_RANGE;
            end else begin
               cursor_in = req_target_position;
            end
         end
         REQ_START: begin
            cursor_in = '0;
         end
         REQ_END: begin
            // empty list keeps the cursor at 0
            cursor_in = (count_ff == '0) ? '0 : CUR_W'(count_ff - CNT_W'(1));
         end
         REQ_PREV: begin
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - CUR_W'(1);
            end
         end
         REQ_NEXT: begin
            if (cursor_ext + CNT_W'(1) < count_ff) begin
               cursor_in = cursor_ff + CUR_W'(1);
            end
         end
         default: begin
            cursor_in = cursor_ff;
         end
      endcase
   end

   // chain command, only on an accepted word
   assign ctl.insert    = accept && do_insert;
   assign ctl.remove    = accept && do_remove;
   assign ctl.cursor    = cursor_ff;
   assign ctl.new_value = req_new_value;

   // row of cells; the first cell sees zero on its left, the last its own value on its right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_W-1:0] left_value;
      logic [ELEM_W-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end
      cal_cell u_cell (
         .clock       (clock),
         .cell_index  (CUR_W'(i)),
         .ctl         (ctl),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_ff   <= read_in;
         rsp_status_ff <= status_in;
         rsp_cursor_ff <= cursor_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cursor_now = rsp_cursor_ff;
   assign rsp_count_now  = rsp_count_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("element count above depth");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) ? (cursor_ff == '0) : (cursor_ext < count_ff))
      else $error("cursor outside the list");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_read_ff == '0))
      else $error("failed request carries data");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && op == REQ_INSERT && status_in == ST_OK)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != ST_OK) |=> $stable(count_ff) && $stable(cursor_ff))
      else $error("failed request changed state");

endmodule
`default_nettype wire

// File: rtl/cal_cell.sv
// One storage cell of the list chain: holds, takes a neighbor's value, or loads a new one.
`default_nettype none
module cal_cell (
   input  wire logic                       clock,
   input  wire logic [cal_pkg::CUR_W-1:0]  cell_index,
   input  wire cal_pkg::cal_ctl_type       ctl,
   input  wire logic [cal_pkg::ELEM_W-1:0] left_value,
   input  wire logic [cal_pkg::ELEM_W-1:0] right_value,
   output logic      [cal_pkg::ELEM_W-1:0] value
);
   import cal_pkg::*;

   logic [ELEM_W-1:0] value_ff;
   logic [ELEM_W-1:0] value_in;

   // insert and remove never come together; neither means hold
   always_comb begin
      value_in = value_ff;
      if (ctl.insert) begin
         if (cell_index == ctl.cursor) begin
            value_in = ctl.new_value;
         end else if (cell_index > ctl.cursor) begin
            value_in = left_value;
         end
      end else if (ctl.remove) begin
         if (cell_index >= ctl.cursor) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// File: verif/tb.sv
// Testbench for cursor_array_list_unit: directed and random request words checked by a scoreboard.
import cal_pkg::*;

// One result word as the block presents it.
typedef struct packed {
   logic [ELEM_W-1:0] read_value;
   logic [ST_W-1:0]   status;
   logic [CUR_W-1:0]  cursor_now;
   logic [CNT_W-1:0]  count_now;
} list_word_type;

// Shadow copy of the list; predicts each result word and checks the block against it.
class list_scoreboard;
   logic [ELEM_W-1:0] cells [DEPTH];
   int                count;
   int                cursor;
   int                capacity;
   int                mismatches;
   list_word_type     awaited [$];

   function new();
      count      = 0;
      cursor     = 0;
      capacity   = DEPTH;
      mismatches = 0;
   endfunction

   function int outstanding();
      return awaited.size();
   endfunction

   // Apply one accepted request to the shadow list and queue the word it yields.
   function void note_request(cal_op_type op, logic [ELEM_W-1:0] value,
                              logic [CUR_W-1:0] target);
      list_word_type w;
      int            room;
      int            i;
      w.read_value = '0;
      w.status     = ST_OK;
      room = (capacity > DEPTH) ? DEPTH : capacity;
      case (op)
         REQ_READ: begin
            if (cursor >= count) w.status = ST_NO_ELEMENT;
            else w.read_value = cells[cursor];
         end
         REQ_INSERT: begin
            if (count >= room || count >= DEPTH || cursor > count) begin
               w.status = ST_FULL;
            end else begin
               for (i = count; i > cursor; i--) cells[i] = cells[i-1];
               cells[cursor] = value;
               count++;
            end
         end
         REQ_REMOVE: begin
            if (cursor >= count) begin
               w.status = ST_NO_ELEMENT;
            end else begin
               w.read_value = cells[cursor];
               for (i = cursor; i + 1 < count; i++) cells[i] = cells[i+1];
               count--;
               if (cursor == count && cursor != 0) cursor--;
            end
         end
         REQ_JUMP: begin
            if (int'(target) >= count) w.status = ST_RANGE;
            else cursor = target;
         end
         REQ_START: cursor = 0;
         REQ_END:   cursor = (count == 0) ? 0 : count - 1;
         REQ_PREV: begin
            if (cursor > 0) cursor--;
         end
         default: begin
            if (cursor + 1 < count) cursor++;
         end
      endcase
      w.cursor_now = CUR_W'(cursor);
      w.count_now  = CNT_W'(count);
      awaited.push_back(w);
   endfunction

   function void check_response(list_word_type seen);
      list_word_type want;
      if (awaited.size() == 0) begin
         if (mismatches < 10)
            $display({"tb: result word with nothing awaited: ",
                      "value %h status %0d cursor %0d count %0d"},
                     seen.read_value, seen.status, seen.cursor_now, seen.count_now);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      if (seen.read_value !== want.read_value || seen.status !== want.status ||
          seen.cursor_now !== want.cursor_now || seen.count_now !== want.count_now) begin
         if (mismatches < 10)
            $display({"tb: mismatch: want value %h status %0d cursor %0d count %0d, ",
                      "got value %h status %0d cursor %0d count %0d"},
                     want.read_value, want.status, want.cursor_now, want.count_now,
                     seen.read_value, seen.status, seen.cursor_now, seen.count_now);
         mismatches++;
      end
   endfunction
endclass

module tb;

   // clock and reset; every block input starts at a known value
   logic                clock               = 1'b0;
   logic                reset               = 1'b1;
   logic                req_valid           = 1'b0;
   logic [OP_W-1:0]     req_type            = REQ_READ;
   logic [ELEM_W-1:0]   req_new_value       = '0;
   logic [CUR_W-1:0]    req_target_position = '0;
   logic                rsp_ready           = 1'b0;
   logic                csr_valid           = 1'b0;
   logic [CNT_W-1:0]    csr_data            = '0;

   logic                req_ready;
   logic                rsp_valid;
   logic [ELEM_W-1:0]   rsp_read_value;
   logic [ST_W-1:0]     rsp_status;
   logic [CUR_W-1:0]    rsp_cursor_now;
   logic [CNT_W-1:0]    rsp_count_now;
   logic                csr_ready;

   // idle odds in percent, per side; changed between phases
   int                  req_idle_pct = 24;
   int                  rsp_idle_pct = 77;

   list_scoreboard      sb;

   // capacity and fill bias per random block: grow blocks favor inserts, others removes
   int                  block_cap  [9] = '{16, 31, 1, 8, 16, 0, 2, 31, 16};
   bit                  block_grow [9] = '{1, 1, 0, 1, 0, 0, 1, 1, 0};

   always #2 clock = ~clock;

   cursor_array_list_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_new_value       (req_new_value),
      .req_target_position (req_target_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_value      (rsp_read_value),
      .rsp_status          (rsp_status),
      .rsp_cursor_now      (rsp_cursor_now),
      .rsp_count_now       (rsp_count_now),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data)
   );

   // Receiver: ready is redrawn at each rising edge; the handshake is sampled at the
   // falling edge, where everything driven at the rising edge has settled, so the
   // word seen there is the one taken at the next rising edge.
   always @(posedge clock) rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(list_word_type'({rsp_read_value, rsp_status,
                                            rsp_cursor_now, rsp_count_now}));
   end

   // Present one request word after a random gap and hold it until it is taken.
   // Acceptance is judged at the falling edge before the taking edge.
   task automatic send_request(cal_op_type op, logic [ELEM_W-1:0] value,
                               logic [CUR_W-1:0] target);
      bit taken;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= op;
      req_new_value       <= value;
      req_target_position <= target;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         if (taken) sb.note_request(op, value, target);
         @(posedge clock);
      end
   endtask

   // Stop sending and wait for every awaited word; one result per request, so
   // once the queue is empty the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Capacity writes only happen with the block idle.
   task automatic set_capacity(logic [CNT_W-1:0] value);
      bit taken;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = csr_ready;
         if (taken) sb.capacity = value;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Random op, biased by fill direction; cursor moves share the tail.
   function automatic cal_op_type pick_op(bit grow);
      int r;
      int ins;
      int rem;
      r   = $urandom_range(99);
      ins = grow ? 50 : 15;
      rem = grow ? 10 : 35;
      if (r < ins) return REQ_INSERT;
      if (r < ins + rem) return REQ_REMOVE;
      if (r < ins + rem + 12) return REQ_READ;
      if (r < ins + rem + 22) return REQ_JUMP;
      case ($urandom_range(3))
         0:       return REQ_START;
         1:       return REQ_END;
         2:       return REQ_PREV;
         default: return REQ_NEXT;
      endcase
   endfunction

   // Jump targets mostly land on an element; the rest cover the whole field.
   function automatic logic [CUR_W-1:0] pick_target();
      if (sb.count > 0 && $urandom_range(3) != 0)
         return CUR_W'($urandom_range(sb.count - 1));
      return CUR_W'($urandom);
   endfunction

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   initial begin : main_flow
      int blk;
      int n;
      cal_op_type op;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty list: reads and removes find nothing, end keeps cursor 0,
      // moves at the edges hold, a jump is out of range
      send_request(REQ_READ,   '0, '0);
      send_request(REQ_REMOVE, '0, '0);
      send_request(REQ_END,    '0, '0);
      send_request(REQ_PREV,   '0, '0);
      send_request(REQ_NEXT,   '0, '0);
      send_request(REQ_JUMP,   '0, '0);
      // build [ones, mid, zero] with inserts at the front and in the middle
      send_request(REQ_INSERT, '0, '0);
      send_request(REQ_INSERT, '1, '1);
      send_request(REQ_NEXT,   '0, '0);
      send_request(REQ_INSERT, 32'hA5A5_5A5A, '0);
      send_request(REQ_END,    '0, '0);
      send_request(REQ_NEXT,   '0, '0);    // already at last element
      send_request(REQ_READ,   '0, '0);
      send_request(REQ_JUMP,   '0, '1);    // past the last element
      send_request(REQ_JUMP,   '0, CUR_W'(1));
      send_request(REQ_READ,   '0, '0);
      send_request(REQ_START,  '0, '0);
      send_request(REQ_PREV,   '0, '0);    // already at 0
      send_request(REQ_END,    '0, '0);
      // removing the last element pulls the cursor back
      send_request(REQ_REMOVE, '0, '0);
      send_request(REQ_REMOVE, '0, '0);
      send_request(REQ_INSERT, 32'h0000_0001, '0);
      // capacity below the count: inserts are refused, elements stay readable
      set_capacity(CNT_W'(1));
      send_request(REQ_INSERT, 32'h8000_0000, '0);
      send_request(REQ_READ,   '0, '0);
      // zero capacity refuses every insert
      set_capacity('0);
      send_request(REQ_INSERT, 32'h1234_5678, '0);

      // random blocks: receiver-heavy idling, then sender-heavy, then none
      for (blk = 0; blk < 9; blk++) begin
         if (blk == 3) begin
            req_idle_pct = 77;
            rsp_idle_pct = 24;
         end else if (blk == 6) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         set_capacity(CNT_W'(block_cap[blk]));
         for (n = 0; n < 50; n++) begin
            op = pick_op(block_grow[blk]);
            send_request(op, pick_value(), pick_target());
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
rtl/cal_pkg.sv
rtl/cal_cell.sv
rtl/cursor_array_list_unit.sv
verif/tb.sv
